// File: sv/vtcc_pkg.sv
`timescale 1ns / 1ps

package vtcc_pkg;

  localparam int CHANNELS  = 8;
  localparam int MASK_BITS = 16;
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0]  WIN_LAST   = 3'd7;
  localparam logic [31:0] COUNT_MASK = (MASK_BITS >= 32) ? 32'hFFFF_FFFF
                                       : 32'((64'd1 << MASK_BITS) - 64'd1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes
  localparam logic [2:0] REG_CALC_START_PHASE  = 3'd0;
  localparam logic [2:0] REG_RANGE_MODE        = 3'd1;
  localparam logic [2:0] REG_DIRECT_COUNT_MODE = 3'd2;
  localparam logic [2:0] REG_COUNT_TO_FREQ     = 3'd3;
  localparam logic [2:0] REG_FREQ_OFFSET       = 3'd4;
  localparam logic [2:0] REG_VOLTS_SCALE       = 3'd5;

  localparam logic [31:0] COUNT_TO_FREQ_RESET = 32'h0001_0000;
  localparam logic [31:0] VOLTS_SCALE_RESET   = 32'h0001_0000;

  // Range mode codes; any other code forces low
  localparam logic [1:0] RANGE_AUTO       = 2'd0;
  localparam logic [1:0] RANGE_FORCE_HIGH = 2'd1;

  // Direct mode: count * 65536 / 51, with 65536 = 51 * 1285 + 1,
  // so the result is count * 1285 + count / 51. The quotient uses a
  // rounded-up reciprocal that is exact for counts below the saturation point.
  localparam int          DIRECT_CNT_W     = 21;
  localparam logic [31:0] DIRECT_MUL       = 32'd1285;
  localparam logic [31:0] DIRECT_RECIP     = 32'd2631721;
  localparam int          DIRECT_SHIFT     = 27;
  localparam logic [31:0] DIRECT_SAT_COUNT = 32'd1671168;

  localparam logic [31:0] VOLTS_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VOLTS_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]  ch;
    logic [31:0] bridge_delta;
    logic [31:0] thermistor_delta;
    logic        range_high;
    logic        done;
    logic        direct;
  } vtcc_job_t;

  typedef struct packed {
    logic [31:0]        count_to_freq;
    logic [31:0]        freq_offset;
    logic signed [31:0] volts_scale;
  } vtcc_conv_cfg_t;

endpackage

// File: sv/vco_temperature_channel_capture_top.sv
// Channel   Handshake           Payload
// in        in_valid/in_stall   phase, channel, bridge_count, thermistor_count
// out       out_valid/out_stall result_channel, bridge_delta, thermistor_delta,
//                               bridge_volts, range_high, window_done
// cfg       cfg_valid/cfg_ready cfg_index, cfg_data
//
// The front takes one tick per cycle while the two-entry job queue has room.
// In the back, one shared 32x32 multiplier is used three times per emitting
// tick (twice in direct mode), plus an offset subtract step and a final
// sum/saturate. Ticks outside a calculation window push no job into the queue.
// Synchronous active-high reset clears the base stores, windows and config.
// A finished result waits in the output register while the next job runs.
`timescale 1ns / 1ps

module vco_temperature_channel_capture_top import vtcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         phase,
  input  logic [2:0]         channel,
  input  logic [31:0]        bridge_count,
  input  logic [31:0]        thermistor_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         result_channel,
  output logic [31:0]        bridge_delta,
  output logic [31:0]        thermistor_delta,
  output logic signed [31:0] bridge_volts,
  output logic               range_high,
  output logic               window_done,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [7:0]     calc_start_phase;
  logic [1:0]     range_mode;
  logic           direct_count_mode;
  vtcc_conv_cfg_t conv_cfg;

  logic           q_full;
  logic           q_push;
  vtcc_job_t      q_push_job;
  logic           q_pop;
  vtcc_job_t      q_head;
  logic           q_nonempty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      calc_start_phase       <= '0;
      range_mode             <= RANGE_AUTO;
      direct_count_mode      <= 1'b0;
      conv_cfg.count_to_freq <= COUNT_TO_FREQ_RESET;
      conv_cfg.freq_offset   <= '0;
      conv_cfg.volts_scale   <= VOLTS_SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CALC_START_PHASE:  calc_start_phase       <= cfg_data[7:0];
        REG_RANGE_MODE:        range_mode             <= cfg_data[1:0];
        REG_DIRECT_COUNT_MODE: direct_count_mode      <= cfg_data[0];
        REG_COUNT_TO_FREQ:     conv_cfg.count_to_freq <= cfg_data;
        REG_FREQ_OFFSET:       conv_cfg.freq_offset   <= cfg_data;
        REG_VOLTS_SCALE:       conv_cfg.volts_scale   <= cfg_data;
        default: ;
      endcase
    end
  end

  vtcc_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .phase             (phase),
    .channel           (channel),
    .bridge_count      (bridge_count),
    .thermistor_count  (thermistor_count),
    .calc_start_phase  (calc_start_phase),
    .range_mode        (range_mode),
    .direct_count_mode (direct_count_mode),
    .q_full            (q_full),
    .push              (q_push),
    .job               (q_push_job)
  );

  vtcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .nonempty (q_nonempty)
  );

  vtcc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_nonempty       (q_nonempty),
    .q_head           (q_head),
    .pop              (q_pop),
    .cfg              (conv_cfg),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_channel   (result_channel),
    .bridge_delta     (bridge_delta),
    .thermistor_delta (thermistor_delta),
    .bridge_volts     (bridge_volts),
    .range_high       (range_high),
    .window_done      (window_done)
  );

endmodule

// File: sv/vtcc_front.sv
`timescale 1ns / 1ps

module vtcc_front import vtcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  phase,
  input  logic [2:0]  channel,
  input  logic [31:0] bridge_count,
  input  logic [31:0] thermistor_count,
  input  logic [7:0]  calc_start_phase,
  input  logic [1:0]  range_mode,
  input  logic        direct_count_mode,
  input  logic        q_full,
  output logic        push,
  output vtcc_job_t   job
);

  logic [31:0]         bridge_base [CHANNELS];
  logic [31:0]         thermistor_base [CHANNELS];
  logic                sampling_on;
  logic                calculating_on;
  logic [2:0]          sample_counter;
  logic [2:0]          calc_counter;
  logic                range_select;

  logic                accept;
  logic                valid_ch;
  logic [CH_IDX_W-1:0] idx;
  logic                samp_open;
  logic                samp_end;
  logic                calc_open;
  logic                calc_end;
  logic [31:0]         bb;
  logic [31:0]         tb;
  logic                range_end;
  logic                range_after;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign valid_ch  = (32'(channel) < 32'(CHANNELS));
  assign idx       = CH_IDX_W'(channel);
  assign samp_open = sampling_on || (phase == 8'd0);
  assign samp_end  = (sample_counter == WIN_LAST);
  assign calc_open = calculating_on || (phase == calc_start_phase);
  assign calc_end  = (calc_counter == WIN_LAST);

  // Base written on this beat bypasses the store
  always_comb begin
    if (!valid_ch) begin
      bb = '0;
      tb = '0;
    end else if (samp_open) begin
      bb = bridge_count;
      tb = thermistor_count;
    end else begin
      bb = bridge_base[idx];
      tb = thermistor_base[idx];
    end
  end

  always_comb begin
    unique case (range_mode)
      RANGE_AUTO:       range_end = !range_select;
      RANGE_FORCE_HIGH: range_end = 1'b1;
      default:          range_end = 1'b0;
    endcase
  end

  assign range_after = calc_end ? range_end : range_select;

  assign push                 = accept && calc_open;
  assign job.ch               = channel;
  assign job.bridge_delta     = direct_count_mode ? bridge_count : (bridge_count - bb);
  assign job.thermistor_delta = thermistor_count - tb;
  assign job.range_high       = range_after;
  assign job.done             = calc_end;
  assign job.direct           = direct_count_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        bridge_base[i]     <= '0;
        thermistor_base[i] <= '0;
      end
      sampling_on    <= 1'b0;
      calculating_on <= 1'b0;
      sample_counter <= '0;
      calc_counter   <= '0;
      range_select   <= 1'b0;
    end else if (accept) begin
      if (samp_open) begin
        if (valid_ch) begin
          bridge_base[idx]     <= bridge_count;
          thermistor_base[idx] <= thermistor_count;
        end
        if (samp_end) begin
          sampling_on    <= 1'b0;
          sample_counter <= '0;
        end else begin
          sampling_on    <= 1'b1;
          sample_counter <= sample_counter + 3'd1;
        end
      end
      if (calc_open) begin
        if (calc_end) begin
          calculating_on <= 1'b0;
          calc_counter   <= '0;
          range_select   <= range_end;
        end else begin
          calculating_on <= 1'b1;
          calc_counter   <= calc_counter + 3'd1;
        end
      end
    end
  end

  a_calc_window_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && calc_open && calc_end) |=> (!calculating_on && calc_counter == 3'd0))
    else $error("calculation window did not close after its last beat");

  a_samp_window_closes: assert property (@(posedge clk) disable iff (rst)
    (accept && samp_open && samp_end) |=> (!sampling_on && sample_counter == 3'd0))
    else $error("sampling window did not close after its last beat");

endmodule

// File: sv/vtcc_queue.sv
`timescale 1ns / 1ps

module vtcc_queue import vtcc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  vtcc_job_t push_job,
  output logic      full,
  input  logic      pop,
  output vtcc_job_t head,
  output logic      nonempty
);

  vtcc_job_t         entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("job pushed into a full queue");

endmodule

// File: sv/vtcc_back.sv
`timescale 1ns / 1ps

module vtcc_back import vtcc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_nonempty,
  input  vtcc_job_t          q_head,
  output logic               pop,
  input  vtcc_conv_cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         result_channel,
  output logic [31:0]        bridge_delta,
  output logic [31:0]        thermistor_delta,
  output logic signed [31:0] bridge_volts,
  output logic               range_high,
  output logic               window_done
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIFF = 5'b00010,
    ST_MLO  = 5'b00100,
    ST_MHI  = 5'b01000,
    ST_FIN  = 5'b10000
  } back_state_t;

  back_state_t state;
  vtcc_job_t   cur;
  logic [63:0] prod;
  logic [63:0] mag;
  logic        dneg;
  logic [31:0] acc;
  logic        rem;

  logic        sneg;
  logic [31:0] ms;
  logic        neg;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] q;
  logic        big;
  logic [31:0] norm_volts;
  logic        dsat;
  logic [31:0] direct_volts;
  logic [31:0] volts;
  logic        out_free;

  assign sneg = cfg.volts_scale[31];
  assign ms   = sneg ? (~cfg.volts_scale + 32'd1) : cfg.volts_scale;
  assign neg  = dneg ^ sneg;

  // One shared multiplier, used three times per item (twice in direct mode)
  always_comb begin
    unique case (state)
      ST_IDLE: begin
        if (q_head.direct) begin
          mul_a = 32'(q_head.bridge_delta[DIRECT_CNT_W-1:0]);
          mul_b = DIRECT_MUL;
        end else begin
          mul_a = q_head.bridge_delta & COUNT_MASK;
          mul_b = cfg.count_to_freq;
        end
      end
      ST_MLO: begin
        if (cur.direct) begin
          mul_a = 32'(cur.bridge_delta[DIRECT_CNT_W-1:0]);
          mul_b = DIRECT_RECIP;
        end else begin
          mul_a = 32'(mag[15:0]);
          mul_b = ms;
        end
      end
      ST_MHI: begin
        mul_a = 32'(mag[46:16]);
        mul_b = ms;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Floor of the signed product: round the magnitude up when negative
  assign q   = prod + 64'(acc) + 64'(neg && rem);
  assign big = |mag[63:47];

  always_comb begin
    if (big) begin
      norm_volts = neg ? VOLTS_MIN : VOLTS_MAX;
    end else if (neg) begin
      norm_volts = (q[63:31] != '0) ? VOLTS_MIN : (~q[31:0] + 32'd1);
    end else begin
      norm_volts = (q >= 64'(VOLTS_MAX)) ? VOLTS_MAX : q[31:0];
    end
  end

  assign dsat         = (cur.bridge_delta >= DIRECT_SAT_COUNT);
  assign direct_volts = dsat ? VOLTS_MAX : (acc + prod[DIRECT_SHIFT +: 32]);
  assign volts        = cur.direct ? direct_volts : norm_volts;

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && q_nonempty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: if (q_nonempty) state <= ST_DIFF;
        ST_DIFF: state <= ST_MLO;
        ST_MLO:  state <= ST_MHI;
        ST_MHI:  state <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_nonempty) begin
          cur  <= q_head;
          prod <= mul_p;
        end
      end
      ST_DIFF: begin
        if (cur.direct) begin
          acc <= prod[31:0];
        end else if (prod < 64'(cfg.freq_offset)) begin
          mag  <= 64'(cfg.freq_offset) - prod;
          dneg <= 1'b1;
        end else begin
          mag  <= prod - 64'(cfg.freq_offset);
          dneg <= 1'b0;
        end
      end
      ST_MLO: prod <= mul_p;
      ST_MHI: begin
        // Hold the direct-mode quotient product in place
        if (!cur.direct) begin
          acc  <= prod[47:16];
          rem  <= |prod[15:0];
          prod <= mul_p;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          result_channel   <= cur.ch;
          bridge_delta     <= cur.bridge_delta;
          thermistor_delta <= cur.thermistor_delta;
          bridge_volts     <= volts;
          range_high       <= cur.range_high;
          window_done      <= cur.done;
        end
      end
      default: ;
    endcase
  end

  a_fin_waits_for_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_valid && out_stall) |=> (state == ST_FIN && out_valid))
    else $error("result dropped while the output slot was occupied");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == ST_DIFF))
    else $error("popped job did not enter the conversion sequence");

endmodule
